@@ hw/rtl/surrogate_spike_gradient_core_defines.svh @@
// ----------------------------------------------------------------------------
// surrogate spike gradient core assertion macros
// shared property wrappers, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef SURROGATE_SPIKE_GRADIENT_CORE_DEFINES_SVH
`define SURROGATE_SPIKE_GRADIENT_CORE_DEFINES_SVH

// condition holds on every clock edge out of reset
`define SSG_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("ssg invariant violated");

// consequent holds in the same cycle as the antecedent
`define SSG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssg implication violated");

// consequent holds in the cycle after the antecedent
`define SSG_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssg next-cycle implication violated");

`endif

@@ hw/rtl/ssg_pkg.sv @@
// ----------------------------------------------------------------------------
// ssg_pkg
// constants, surrogate kind codes, register indices and the exponent table of the core
// ----------------------------------------------------------------------------
package ssg_pkg;

  localparam int DIV_NUM_W = 57;
  localparam int DIV_DEN_W = 49;
  localparam int DIV_QUO_W = 36;
  localparam int DIV_LAT   = DIV_QUO_W;

  localparam int EXP_STEPS = 16;
  localparam int EXP_LAT   = EXP_STEPS + 2;

  localparam logic [15:0] BETA_RESET       = 16'd1280;
  localparam logic [16:0] ONE_Q16          = 17'd65536;
  localparam logic [16:0] LOG2E_Q16        = 17'd94548;
  localparam logic [14:0] INV_SQRT_2PI_Q16 = 15'd26145;

  // 2^-(2^-k) in q.16 for the fraction bits from the top down
  localparam logic [15:0] POW2NEG [EXP_STEPS] = '{
    16'd46341, 16'd55109, 16'd60097, 16'd62757, 16'd64132, 16'd64830, 16'd65182, 16'd65359,
    16'd65447, 16'd65492, 16'd65514, 16'd65525, 16'd65530, 16'd65533, 16'd65535, 16'd65535
  };

  typedef enum logic [2:0] {
    KIND_NONE         = 3'd0,
    KIND_SIGMOID      = 3'd1,
    KIND_FAST_SIGMOID = 3'd2,
    KIND_ARCTAN       = 3'd3,
    KIND_TRIANGLE     = 3'd4,
    KIND_SUPERSPIKE   = 3'd5,
    KIND_MULTI_GAUSS  = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_SHARPNESS = 2'd1,
    REG_KIND      = 2'd2,
    REG_DIVIDE    = 2'd3
  } reg_idx_t;

endpackage

@@ hw/rtl/ssg_div.sv @@
// ----------------------------------------------------------------------------
// ssg_div
// pipelined restoring divider, one quotient bit per register stage
// ----------------------------------------------------------------------------
module ssg_div (
  input  logic                           clk,
  input  logic                           en,
  input  logic [ssg_pkg::DIV_NUM_W-1:0]  num,
  input  logic [ssg_pkg::DIV_DEN_W-1:0]  den,
  output logic [ssg_pkg::DIV_QUO_W-1:0]  quo
);

  localparam int NumW = ssg_pkg::DIV_NUM_W;
  localparam int DenW = ssg_pkg::DIV_DEN_W;
  localparam int QuoW = ssg_pkg::DIV_QUO_W;
  localparam int CmpW = DenW + QuoW;

  logic [NumW-1:0] rem_r [QuoW-1];
  logic [DenW-1:0] den_r [QuoW-1];
  logic [QuoW-1:0] quo_r [QuoW];

  for (genvar i = 0; i < QuoW; i++) begin : g_stage
    localparam int Sh = QuoW - 1 - i;
    logic [NumW-1:0] rem_in;
    logic [DenW-1:0] den_in;
    logic [QuoW-1:0] quo_in;
    logic [CmpW-1:0] dsh;
    logic            ge;

    if (i == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign den_in = den_r[i-1];
      assign quo_in = quo_r[i-1];
    end

    assign dsh = {{QuoW{1'b0}}, den_in} << Sh;
    assign ge  = {{(CmpW-NumW){1'b0}}, rem_in} >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[i] <= quo_in | (ge ? (QuoW'(1) << Sh) : '0);
      end
    end

    if (i < QuoW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i] <= ge ? rem_in - dsh[NumW-1:0] : rem_in;
          den_r[i] <= den_in;
        end
      end
    end
  end

  assign quo = quo_r[QuoW-1];

endmodule

@@ hw/rtl/ssg_exp.sv @@
// ----------------------------------------------------------------------------
// ssg_exp
// pipelined e^-y in q.16, one table multiply per fraction bit
// ----------------------------------------------------------------------------
module ssg_exp (
  input  logic        clk,
  input  logic        en,
  input  logic        zero,
  input  logic [23:0] y,
  output logic [16:0] e
);

  localparam int Steps = ssg_pkg::EXP_STEPS;

  logic [40:0] zp;
  logic [8:0]  k_r    [Steps+1];
  logic        zero_r [Steps+1];
  logic [15:0] f_r    [Steps];
  logic [16:0] r_r    [1:Steps];
  logic [16:0] e_r;

  assign zp = 41'(y) * 41'(ssg_pkg::LOG2E_Q16);

  always_ff @(posedge clk) begin
    if (en) begin
      k_r[0]    <= zp[40:32];
      f_r[0]    <= zp[31:16];
      zero_r[0] <= zero;
    end
  end

  for (genvar i = 0; i < Steps; i++) begin : g_step
    logic [16:0] r_in;
    logic [32:0] prod;

    if (i == 0) begin : g_first
      assign r_in = ssg_pkg::ONE_Q16;
    end else begin : g_next
      assign r_in = r_r[i];
    end

    assign prod = 33'(r_in) * 33'(ssg_pkg::POW2NEG[i]) + 33'd32768;

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[i+1]    <= f_r[i][Steps-1-i] ? prod[32:16] : r_in;
        k_r[i+1]    <= k_r[i];
        zero_r[i+1] <= zero_r[i];
      end
    end

    if (i < Steps - 1) begin : g_frac
      always_ff @(posedge clk) begin
        if (en) begin
          f_r[i+1] <= f_r[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_r <= (zero_r[Steps] || k_r[Steps] > 9'd16) ? '0 : r_r[Steps] >> k_r[Steps][4:0];
    end
  end

  assign e = e_r;

endmodule

@@ hw/rtl/surrogate_spike_gradient_core.sv @@
// ----------------------------------------------------------------------------
// surrogate_spike_gradient_core
// surrogate derivative of a spiking neuron applied to an upstream gradient
// ----------------------------------------------------------------------------
// One element beat enters per cycle and one result beat leaves per cycle
// while the output is accepted. The pipeline depth is set mainly by the
// three pipelined dividers (36 quotient-bit stages each) and the 18-stage
// exponent unit, all of which accept a new operand every cycle.
// A two-entry output buffer keeps the input side open while a result waits;
// the pipeline holds only while that buffer is full. Configuration registers
// must be written while no element is in flight.
// ----------------------------------------------------------------------------
`include "surrogate_spike_gradient_core_defines.svh"

module surrogate_spike_gradient_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] potential, [31:16] upstream_gradient
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] input_gradient
  output logic        out_tlast
);

  localparam int ExpLat = ssg_pkg::EXP_LAT;
  localparam int DivLat = ssg_pkg::DIV_LAT;
  localparam int NumW   = ssg_pkg::DIV_NUM_W;
  localparam int DenW   = ssg_pkg::DIV_DEN_W;
  localparam int QuoW   = ssg_pkg::DIV_QUO_W;
  localparam int PosE   = 3 + ExpLat;
  localparam int PosS1  = PosE + DivLat;
  localparam int PipeLat = PosE + 1 + 3 * DivLat + 4;

  typedef struct packed {
    logic signed [15:0] g;
    logic               last;
    logic [48:0]        q;
    logic [32:0]        d;
    logic [24:0]        tri_v;
  } xs_t;

  typedef struct packed {
    logic signed [15:0] g;
    logic               last;
    logic [32:0]        d;
    logic [24:0]        tri_v;
    logic [34:0]        gp;
  } s1_t;

  typedef struct packed {
    logic signed [15:0] g;
    logic               last;
    logic [24:0]        spre;
  } s2_t;

  typedef struct packed {
    logic neg;
    logic last;
  } s3_t;

  typedef struct packed {
    logic [31:0] res;
    logic        last;
  } res_t;

  // configuration
  logic signed [15:0]    th_r;
  logic [15:0]           beta_r;
  ssg_pkg::kind_t        kind_r;
  logic                  divth_r;
  logic [15:0]           b_eff;
  logic [18:0]           den3;
  logic [18:0]           half3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      th_r    <= 16'sd256;
      beta_r  <= ssg_pkg::BETA_RESET;
      kind_r  <= ssg_pkg::KIND_SIGMOID;
      divth_r <= 1'b1;
    end else if (cfg_we) begin
      case (ssg_pkg::reg_idx_t'(cfg_index))
        ssg_pkg::REG_THRESHOLD: th_r    <= signed'(cfg_wdata);
        ssg_pkg::REG_SHARPNESS: beta_r  <= cfg_wdata;
        ssg_pkg::REG_KIND:      kind_r  <= ssg_pkg::kind_t'(cfg_wdata[2:0]);
        ssg_pkg::REG_DIVIDE:    divth_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign b_eff = (beta_r == 16'd0) ? ssg_pkg::BETA_RESET : beta_r;
  assign den3  = (divth_r && !th_r[15] && th_r != 16'sd0) ? {th_r[14:0], 4'b0} : 19'd4096;
  assign half3 = den3 >> 1;

  // flow control
  logic               en;
  logic [1:0]         cnt_r;
  logic [PipeLat-1:0] vld_r;
  logic               push;
  logic               pop;

  assign en        = (cnt_r != 2'd2);
  assign in_tready = en && rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PipeLat-2:0], in_tvalid};
    end
  end

  // stage a: offset from threshold
  logic signed [16:0] a_x_r;
  logic signed [15:0] a_g_r;
  logic               a_last_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a_x_r    <= {in_tdata[15], in_tdata[15:0]} - {th_r[15], th_r};
      a_g_r    <= signed'(in_tdata[31:16]);
      a_last_r <= in_tlast;
    end
  end

  // stage b: scale by beta
  logic [16:0]        ax;
  logic signed [17:0] dg [3];
  logic [16:0]        mg [3];
  logic [31:0]        b_a_r;
  logic [32:0]        b_u_r [3];
  logic signed [15:0] b_g_r;
  logic               b_last_r;

  assign ax    = a_x_r[16] ? 17'(-a_x_r) : a_x_r;
  assign dg[0] = {a_x_r[16], a_x_r};
  assign dg[1] = {a_x_r[16], a_x_r} - 18'sd128;
  assign dg[2] = {a_x_r[16], a_x_r} + 18'sd128;

  for (genvar i = 0; i < 3; i++) begin : g_gabs
    logic [17:0] dneg;
    assign dneg  = 18'(-dg[i]);
    assign mg[i] = dg[i][17] ? dneg[16:0] : dg[i][16:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_a_r    <= 32'(ax[15:0]) * 32'(b_eff);
      for (int i = 0; i < 3; i++) begin
        b_u_r[i] <= 33'(mg[i]) * 33'(b_eff);
      end
      b_g_r    <= a_g_r;
      b_last_r <= a_last_r;
    end
  end

  // stage c: squares, triangle and exponent arguments
  logic [63:0] aa;
  logic [16:0] tri_diff;
  logic [32:0] tri_p;
  logic        c_ez_r [3];
  logic [23:0] c_ey_r [3];
  logic        ez     [3];
  logic [23:0] ey     [3];
  xs_t         c_r;

  assign aa       = 64'(b_a_r) * 64'(b_a_r);
  assign tri_diff = ssg_pkg::ONE_Q16 - b_a_r[16:0];
  assign tri_p    = 33'(tri_diff) * 33'(b_eff);

  for (genvar i = 0; i < 3; i++) begin : g_garg
    logic [47:0] uu;
    logic [30:0] yy;
    assign uu = 48'(b_u_r[i][23:0]) * 48'(b_u_r[i][23:0]);
    assign yy = uu[47:17];
    if (i == 0) begin : g_lane0
      assign ez[i] = (kind_r == ssg_pkg::KIND_SIGMOID) ? (b_a_r[31:24] != 8'd0)
                   : (b_u_r[i][32:24] != 9'd0 || yy[30:24] != 7'd0);
      assign ey[i] = (kind_r == ssg_pkg::KIND_SIGMOID) ? b_a_r[23:0] : yy[23:0];
    end else begin : g_lane
      assign ez[i] = b_u_r[i][32:24] != 9'd0 || yy[30:24] != 7'd0;
      assign ey[i] = yy[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        c_ez_r[i] <= ez[i];
        c_ey_r[i] <= ey[i];
      end
      c_r.g     <= b_g_r;
      c_r.last  <= b_last_r;
      c_r.q     <= 49'(aa[63:16]) + 49'(ssg_pkg::ONE_Q16);
      c_r.d     <= 33'(b_a_r) + 33'(ssg_pkg::ONE_Q16);
      c_r.tri_v <= (b_a_r < 32'(ssg_pkg::ONE_Q16)) ? tri_p[32:8] : 25'd0;
    end
  end

  // exponent lanes
  logic [16:0] e_w [3];
  xs_t         sx_r [ExpLat];

  for (genvar i = 0; i < 3; i++) begin : g_exp
    ssg_exp u_exp (
      .clk  (clk),
      .en   (en),
      .zero (c_ez_r[i]),
      .y    (c_ey_r[i]),
      .e    (e_w[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx_r[0] <= c_r;
      for (int i = 1; i < ExpLat; i++) begin
        sx_r[i] <= sx_r[i-1];
      end
    end
  end

  // stage e: sigmoid operands and gaussian sum
  logic [32:0]        be_p;
  logic [17:0]        e1p;
  logic [56:0]        e_num_r;
  logic [35:0]        e_den_r;
  logic [18:0]        e_s2_r;
  xs_t                e_r;

  assign be_p = 33'(b_eff) * 33'(e_w[0]);
  assign e1p  = 18'(e_w[0]) + 18'(ssg_pkg::ONE_Q16);

  always_ff @(posedge clk) begin
    if (en) begin
      e_num_r <= {be_p, 24'b0};
      e_den_r <= 36'(e1p) * 36'(e1p);
      e_s2_r  <= 19'({e_w[0], 1'b0}) + 19'(e_w[1]) + 19'(e_w[2]);
      e_r     <= sx_r[ExpLat-1];
    end
  end

  // first divider
  logic [NumW-1:0] div1_num;
  logic [DenW-1:0] div1_den;
  logic [QuoW-1:0] q1;
  s1_t             s1_r [DivLat];

  always_comb begin
    div1_num = '0;
    div1_den = DenW'(1);
    case (kind_r)
      ssg_pkg::KIND_SIGMOID: begin
        div1_num = e_num_r;
        div1_den = DenW'(e_den_r);
      end
      ssg_pkg::KIND_FAST_SIGMOID: begin
        div1_num = NumW'({b_eff, 24'b0});
        div1_den = DenW'(e_r.d);
      end
      ssg_pkg::KIND_ARCTAN: begin
        div1_num = NumW'({b_eff, 24'b0});
        div1_den = e_r.q;
      end
      ssg_pkg::KIND_SUPERSPIKE: begin
        div1_num = NumW'(1) << 32;
        div1_den = DenW'(e_r.d);
      end
      default: ;
    endcase
  end

  ssg_div u_div1 (
    .clk (clk),
    .en  (en),
    .num (div1_num),
    .den (div1_den),
    .quo (q1)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r[0].g     <= e_r.g;
      s1_r[0].last  <= e_r.last;
      s1_r[0].d     <= e_r.d;
      s1_r[0].tri_v <= e_r.tri_v;
      s1_r[0].gp    <= 35'(e_s2_r) * 35'(b_eff);
      for (int i = 1; i < DivLat; i++) begin
        s1_r[i] <= s1_r[i-1];
      end
    end
  end

  // stage h: direct surrogates and second divide operands
  logic [49:0]        gs_p;
  logic [24:0]        spre;
  logic [23:0]        h_t_r;
  logic [32:0]        h_d_r;
  logic [24:0]        h_spre_r;
  logic signed [15:0] h_g_r;
  logic               h_last_r;

  assign gs_p = 50'(s1_r[DivLat-1].gp) * 50'(ssg_pkg::INV_SQRT_2PI_Q16);

  always_comb begin
    case (kind_r)
      ssg_pkg::KIND_SIGMOID,
      ssg_pkg::KIND_ARCTAN:      spre = 25'(q1[23:0]);
      ssg_pkg::KIND_TRIANGLE:    spre = s1_r[DivLat-1].tri_v;
      ssg_pkg::KIND_MULTI_GAUSS: spre = gs_p[49:25];
      default:                   spre = 25'(ssg_pkg::ONE_Q16);
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_t_r    <= q1[23:0];
      h_d_r    <= s1_r[DivLat-1].d;
      h_spre_r <= spre;
      h_g_r    <= s1_r[DivLat-1].g;
      h_last_r <= s1_r[DivLat-1].last;
    end
  end

  // second divider
  logic [QuoW-1:0] q2;
  s2_t             s2_r [DivLat];

  ssg_div u_div2 (
    .clk (clk),
    .en  (en),
    .num (NumW'({h_t_r, 16'b0})),
    .den (DenW'(h_d_r)),
    .quo (q2)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r[0].g    <= h_g_r;
      s2_r[0].last <= h_last_r;
      s2_r[0].spre <= h_spre_r;
      for (int i = 1; i < DivLat; i++) begin
        s2_r[i] <= s2_r[i-1];
      end
    end
  end

  // stage i: gradient product, stage j: rounding offset
  logic [24:0] s_sel;
  logic [15:0] gm;
  logic [40:0] i_m_r;
  logic        i_neg_r;
  logic        i_last_r;
  logic [40:0] j_num_r;
  logic        j_neg_r;
  logic        j_last_r;

  always_comb begin
    case (kind_r)
      ssg_pkg::KIND_FAST_SIGMOID,
      ssg_pkg::KIND_SUPERSPIKE: s_sel = q2[24:0];
      default:                  s_sel = s2_r[DivLat-1].spre;
    endcase
  end

  assign gm = s2_r[DivLat-1].g[15] ? 16'(-s2_r[DivLat-1].g) : s2_r[DivLat-1].g;

  always_ff @(posedge clk) begin
    if (en) begin
      i_m_r    <= 41'(gm) * 41'(s_sel);
      i_neg_r  <= s2_r[DivLat-1].g[15];
      i_last_r <= s2_r[DivLat-1].last;
      j_num_r  <= i_m_r + 41'(half3);
      j_neg_r  <= i_neg_r;
      j_last_r <= i_last_r;
    end
  end

  // third divider
  logic [QuoW-1:0] q3;
  s3_t             s3_r [DivLat];

  ssg_div u_div3 (
    .clk (clk),
    .en  (en),
    .num (NumW'(j_num_r)),
    .den (DenW'(den3)),
    .quo (q3)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r[0].neg  <= j_neg_r;
      s3_r[0].last <= j_last_r;
      for (int i = 1; i < DivLat; i++) begin
        s3_r[i] <= s3_r[i-1];
      end
    end
  end

  // stage k: sign and saturation
  logic [31:0] res_nxt;
  res_t        k_r;

  always_comb begin
    if (s3_r[DivLat-1].neg) begin
      res_nxt = (q3 > 36'h080000000) ? 32'h80000000 : 32'(-q3[31:0]);
    end else begin
      res_nxt = (q3 > 36'h07fffffff) ? 32'h7fffffff : q3[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k_r.res  <= res_nxt;
      k_r.last <= s3_r[DivLat-1].last;
    end
  end

  // output buffer
  res_t       fifo_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_nxt;

  assign push    = en && vld_r[PipeLat-1];
  assign pop     = out_tvalid && out_tready;
  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= k_r;
    end
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = fifo_r[rd_ptr_r].res;
  assign out_tlast  = fifo_r[rd_ptr_r].last;

  // checks
  logic div1_used;

  assign div1_used = kind_r inside {ssg_pkg::KIND_SIGMOID, ssg_pkg::KIND_ARCTAN,
                                    ssg_pkg::KIND_FAST_SIGMOID, ssg_pkg::KIND_SUPERSPIKE};

  `SSG_ASSERT_ALWAYS(a_buf_bound, cnt_r <= 2'd2)
  `SSG_ASSERT_NXT(a_hold_on_stall, vld_r[PipeLat-1] && !en, vld_r[PipeLat-1])
  `SSG_ASSERT_IMP(a_div1_range, vld_r[PosS1] && div1_used, q1[QuoW-1:24] == '0)

endmodule
